### rtl/beq_pkg.sv
// Shared types and constants for the button event qualifier.
package beq_pkg;

   // Button codes carried in the result word.
   localparam logic [2:0] CODE_NONE     = 3'd0;
   localparam logic [2:0] CODE_BUTTON1  = 3'd1;
   localparam logic [2:0] CODE_BUTTON2  = 3'd2;
   localparam logic [2:0] CODE_BUTTON3  = 3'd3;
   localparam logic [2:0] CODE_BUTTON4  = 3'd4;
   localparam logic [2:0] CODE_EXTERNAL = 3'd5;

   // Interrupt channels that carry buttons.
   localparam logic [3:0] CH_BUTTON1  = 4'd9;
   localparam logic [3:0] CH_BUTTON2  = 4'd4;
   localparam logic [3:0] CH_BUTTON3  = 4'd6;
   localparam logic [3:0] CH_BUTTON4  = 4'd7;
   localparam logic [3:0] CH_EXTERNAL = 4'd5;

   // System modes; the unused code behaves as normal mode.
   localparam logic [1:0] MODE_NORMAL     = 2'd0;
   localparam logic [1:0] MODE_POWER_UP   = 2'd1;
   localparam logic [1:0] MODE_POWER_DOWN = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
   localparam logic [1:0] REG_CLICK_WIN   = 2'd1;
   localparam logic [1:0] REG_WAKE_CLICKS = 2'd2;

   // Configuration reset values.
   localparam logic [15:0] DEBOUNCE_RESET    = 16'd50;
   localparam logic [15:0] CLICK_WIN_RESET   = 16'd500;
   localparam logic [3:0]  WAKE_CLICKS_RESET = 4'd3;

   // Saturation limit of the click counter.
   localparam logic [3:0] CLICK_MAX = 4'd15;

   typedef struct packed {
      logic [15:0] debounce_interval;
      logic [15:0] quick_click_window;
      logic [3:0]  wake_click_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  system_mode;
      logic [31:0] now_ms;
      logic [3:0]  event_channel;
   } event_type;

   typedef struct packed {
      logic       hold_timer_stop;
      logic       hold_timer_start;
      logic [2:0] button_code;
   } result_type;

   // Scalar qualifier state shared by all channels.
   typedef struct packed {
      logic [31:0] last_accept_ms;
      logic [31:0] last_click_ms;
      logic [3:0]  click_count;
      logic        external_held;
   } qual_state_type;

endpackage

### rtl/beq_decide.sv
// Combinational qualification of one event word against the current state.
module beq_decide (
   input  beq_pkg::cfg_type        cfg,
   input  beq_pkg::event_type      evt,
   input  logic                    pressed,
   input  beq_pkg::qual_state_type state_cur,
   output beq_pkg::qual_state_type state_next,
   output logic                    handled,
   output beq_pkg::result_type     result
);

   logic [2:0]  cand;
   logic [31:0] accept_age;
   logic [31:0] click_age;
   logic        debounce_ok;
   logic        quick_click;
   logic [3:0]  click_bumped;

   // Map the channel to its candidate button code.
   always_comb begin
      case (evt.event_channel)
         beq_pkg::CH_BUTTON1:  cand = beq_pkg::CODE_BUTTON1;
         beq_pkg::CH_BUTTON2:  cand = beq_pkg::CODE_BUTTON2;
         beq_pkg::CH_BUTTON3:  cand = beq_pkg::CODE_BUTTON3;
         beq_pkg::CH_BUTTON4:  cand = beq_pkg::CODE_BUTTON4;
         beq_pkg::CH_EXTERNAL: cand = beq_pkg::CODE_EXTERNAL;
         default:              cand = beq_pkg::CODE_NONE;
      endcase
   end

   // Elapsed times, taken modulo 2^32.
   assign accept_age  = evt.now_ms - state_cur.last_accept_ms;
   assign click_age   = evt.now_ms - state_cur.last_click_ms;
   assign debounce_ok = accept_age > {16'd0, cfg.debounce_interval};
   assign quick_click = click_age < {16'd0, cfg.quick_click_window};
   assign handled     = (cand != beq_pkg::CODE_NONE);

   // Power-down click count: 1 past the window, else +1 up to the limit.
   always_comb begin
      if (!quick_click) begin
         click_bumped = 4'd1;
      end else if (state_cur.click_count < beq_pkg::CLICK_MAX) begin
         click_bumped = state_cur.click_count + 4'd1;
      end else begin
         click_bumped = state_cur.click_count;
      end
   end

   // Decide the result word and the state update.
   always_comb begin
      state_next = state_cur;
      result     = '0;
      if (handled) begin
         if (cand != beq_pkg::CODE_EXTERNAL) begin
            if (pressed && debounce_ok) begin
               result.button_code        = cand;
               state_next.last_accept_ms = evt.now_ms;
            end
         end else if (evt.system_mode == beq_pkg::MODE_POWER_UP) begin
            // The external button is ignored while powering up.
         end else if (evt.system_mode == beq_pkg::MODE_POWER_DOWN) begin
            if (pressed) begin
               state_next.last_click_ms = evt.now_ms;
               if (click_bumped >= cfg.wake_click_count) begin
                  state_next.click_count = 4'd0;
                  if (debounce_ok) begin
                     result.button_code        = beq_pkg::CODE_EXTERNAL;
                     state_next.last_accept_ms = evt.now_ms;
                  end
               end else begin
                  state_next.click_count = click_bumped;
               end
            end
         end else begin
            // Normal mode: press starts the hold timer, release stops it.
            if (pressed) begin
               if (!state_cur.external_held) begin
                  state_next.external_held = 1'b1;
                  result.hold_timer_start  = 1'b1;
               end
            end else begin
               state_next.external_held = 1'b0;
               result.hold_timer_stop   = 1'b1;
               if (debounce_ok) begin
                  result.button_code        = beq_pkg::CODE_EXTERNAL;
                  state_next.last_accept_ms = evt.now_ms;
               end
            end
         end
      end
   end

endmodule

### rtl/button_event_qualifier.sv
// Top level of the button event qualifier: registers, handshakes and config.
// A request word is held in the input register, then its response word in the response register.
// Throughput: one word per cycle while the receiver takes responses; the decision logic
// between the input register and the response register keeps all state in one clock.
// Reset: synchronous and active high; all sense bits return to detect-low,
// timestamps, click count and hold flag clear, registers take their defaults.
module button_event_qualifier #(
   parameter int CHANNELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request: event_channel[3:0], now_ms[35:4], system_mode[37:36], zero pad.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // Response: button_code[2:0], hold_timer_start[3], hold_timer_stop[4], pad.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   beq_pkg::cfg_type        cfg_ff, cfg_in;
   beq_pkg::event_type      evt_ff;
   logic                    evt_valid_ff;
   beq_pkg::qual_state_type state_ff, state_in;
   logic [CHANNELS-1:0]     sense_ff;
   logic [CHANNELS-1:0]     hit;
   beq_pkg::result_type     rsp_ff, result;
   logic                    rsp_valid_ff;
   logic                    rsp_free;
   logic                    load;
   logic                    pressed;
   logic                    handled;

   // Handshake: the input register moves on whenever the response slot frees.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign load       = evt_valid_ff && rsp_free;
   assign req_tready = !evt_valid_ff || rsp_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_ff};

   // One-hot select of the event channel among the sense bits.
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         hit[i] = ({28'd0, evt_ff.event_channel} == 32'(i));
      end
   end
   assign pressed = |(sense_ff & hit);

   beq_decide u_decide (
      .cfg        (cfg_ff),
      .evt        (evt_ff),
      .pressed    (pressed),
      .state_cur  (state_ff),
      .state_next (state_in),
      .handled    (handled),
      .result     (result)
   );

   // Configuration register decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            beq_pkg::REG_DEBOUNCE:    cfg_in.debounce_interval  = csr_wdata;
            beq_pkg::REG_CLICK_WIN:   cfg_in.quick_click_window = csr_wdata;
            beq_pkg::REG_WAKE_CLICKS: cfg_in.wake_click_count   = csr_wdata[3:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_interval  <= beq_pkg::DEBOUNCE_RESET;
         cfg_ff.quick_click_window <= beq_pkg::CLICK_WIN_RESET;
         cfg_ff.wake_click_count   <= beq_pkg::WAKE_CLICKS_RESET;
         evt_valid_ff              <= 1'b0;
         rsp_valid_ff              <= 1'b0;
         state_ff                  <= '0;
         sense_ff                  <= '1;
      end else begin
         cfg_ff <= cfg_in;
         if (req_tready) begin
            evt_valid_ff <= req_tvalid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= evt_valid_ff;
         end
         if (load) begin
            state_ff <= state_in;
            if (handled) begin
               sense_ff <= sense_ff ^ hit;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         evt_ff <= req_tdata[37:0];
      end
      if (load) begin
         rsp_ff <= result;
      end
   end

   // A response never starts and stops the hold timer at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.hold_timer_start && rsp_ff.hold_timer_stop))
      else $error("hold timer start and stop in one word");

   // A start pulse leaves the external button marked as held.
   assert property (@(posedge clock) disable iff (reset)
      (load && result.hold_timer_start) |=> state_ff.external_held)
      else $error("start pulse without held flag");

   // A stop pulse clears the held flag.
   assert property (@(posedge clock) disable iff (reset)
      (load && result.hold_timer_stop) |=> !state_ff.external_held)
      else $error("stop pulse left held flag set");

   // An emitted code records its timestamp for the debounce check.
   assert property (@(posedge clock) disable iff (reset)
      (load && result.button_code != beq_pkg::CODE_NONE)
         |=> state_ff.last_accept_ms == $past(evt_ff.now_ms))
      else $error("accepted code did not update debounce time");

endmodule

### test/tb_button_event_qualifier.sv
`timescale 1ns / 100ps
// Testbench for the button event qualifier: directed and random events against a predictor.
module tb_button_event_qualifier;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int SETTLE_CYCLES = 6;
   // The spare mode code has no name in the package; it behaves as normal mode.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // event_channel[3:0], now_ms[35:4], system_mode[37:36], zero pad.
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // button_code[2:0], hold_timer_start[3], hold_timer_stop[4], zero pad.
   logic [7:0]  rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = beq_pkg::REG_DEBOUNCE;
   logic [15:0] csr_wdata = '0;

   // Predictor copy of the configuration and qualifier state.
   logic [15:0] settle_gap_ms;
   logic [15:0] click_window_ms;
   logic [3:0]  wake_clicks;
   logic [15:0] sense_low;
   logic [31:0] last_accept_ms;
   logic [31:0] last_click_ms;
   logic [3:0]  click_count;
   logic        external_held;

   beq_pkg::result_type expected_results[$];
   beq_pkg::result_type rsp_word;
   beq_pkg::result_type due_word;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_off_req = 1'b0;
   int          hold_off_left = 0;
   logic [31:0] stamp_ms = '0;
   logic [1:0]  traffic_mode = beq_pkg::MODE_NORMAL;

   button_event_qualifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Shared debounce gate: passes when strictly more than the interval has elapsed.
   function automatic logic debounce_ok(logic [31:0] now);
      logic [31:0] elapsed;
      elapsed = now - last_accept_ms;
      if (elapsed > {16'd0, settle_gap_ms}) begin
         last_accept_ms = now;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the response word for one event and advances the predictor state.
   function automatic beq_pkg::result_type qualify_event(beq_pkg::event_type ev);
      beq_pkg::result_type res;
      logic [2:0]  cand;
      logic        pressed;
      logic [31:0] since_click;
      res = '0;
      case (ev.event_channel)
         beq_pkg::CH_BUTTON1: cand = beq_pkg::CODE_BUTTON1;
         beq_pkg::CH_BUTTON2: cand = beq_pkg::CODE_BUTTON2;
         beq_pkg::CH_BUTTON3: cand = beq_pkg::CODE_BUTTON3;
         beq_pkg::CH_BUTTON4: cand = beq_pkg::CODE_BUTTON4;
         beq_pkg::CH_EXTERNAL: cand = beq_pkg::CODE_EXTERNAL;
         default: cand = beq_pkg::CODE_NONE;
      endcase
      // Unused channels leave everything untouched, their sense bit included.
      if (cand == beq_pkg::CODE_NONE)
         return res;
      pressed = sense_low[ev.event_channel];
      sense_low[ev.event_channel] = ~pressed;
      if (cand != beq_pkg::CODE_EXTERNAL) begin
         if (pressed) begin
            if (debounce_ok(ev.now_ms))
               res.button_code = cand;
         end
      end else if (ev.system_mode == beq_pkg::MODE_POWER_UP) begin
         // The external button is ignored while powering up.
      end else if (ev.system_mode == beq_pkg::MODE_POWER_DOWN) begin
         // Count quick clicks; enough of them in a row wake the system.
         if (pressed) begin
            since_click = ev.now_ms - last_click_ms;
            if (since_click < {16'd0, click_window_ms}) begin
               if (click_count < beq_pkg::CLICK_MAX)
                  click_count = click_count + 4'd1;
            end else begin
               click_count = 4'd1;
            end
            last_click_ms = ev.now_ms;
            if (click_count >= wake_clicks) begin
               click_count = '0;
               if (debounce_ok(ev.now_ms))
                  res.button_code = beq_pkg::CODE_EXTERNAL;
            end
         end
      end else if (pressed) begin
         // A press while already held does not restart the hold timer.
         if (!external_held) begin
            external_held = 1'b1;
            res.hold_timer_start = 1'b1;
         end
      end else begin
         external_held = 1'b0;
         res.hold_timer_stop = 1'b1;
         if (debounce_ok(ev.now_ms))
            res.button_code = beq_pkg::CODE_EXTERNAL;
      end
      return res;
   endfunction

   // Predict on each accepted request word, then check each accepted response word.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_results.push_back(
               qualify_event(beq_pkg::event_type'(req_tdata[37:0])));
         if (rsp_tvalid && rsp_tready) begin
            rsp_word = beq_pkg::result_type'(rsp_tdata[4:0]);
            if (expected_results.size() == 0) begin
               $error("response word %h arrived with nothing expected", rsp_tdata);
               mismatch_count++;
            end else begin
               due_word = expected_results.pop_front();
               if (rsp_word.button_code !== due_word.button_code) begin
                  $error("button_code: expected %0d, got %0d",
                         due_word.button_code, rsp_word.button_code);
                  mismatch_count++;
               end
               if (rsp_word.hold_timer_start !== due_word.hold_timer_start) begin
                  $error("hold_timer_start: expected %0b, got %0b",
                         due_word.hold_timer_start, rsp_word.hold_timer_start);
                  mismatch_count++;
               end
               if (rsp_word.hold_timer_stop !== due_word.hold_timer_stop) begin
                  $error("hold_timer_stop: expected %0b, got %0b",
                         due_word.hold_timer_stop, rsp_word.hold_timer_stop);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off counted here when requested.
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offers one event word; entered and left at a falling edge.
   task automatic send_event(input logic [3:0] ch, input logic [31:0] now,
                             input logic [1:0] mode);
      beq_pkg::event_type ev;
      ev.event_channel = ch;
      ev.now_ms = now;
      ev.system_mode = mode;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, ev};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Stops offering and waits until every expected word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes all three registers while the block is idle.
   task automatic apply_settings(input logic [15:0] deb, input logic [15:0] win,
                                 input logic [3:0] wake);
      csr_wr_en <= 1'b1;
      csr_index <= beq_pkg::REG_DEBOUNCE;
      csr_wdata <= deb;
      @(negedge clock);
      csr_index <= beq_pkg::REG_CLICK_WIN;
      csr_wdata <= win;
      @(negedge clock);
      csr_index <= beq_pkg::REG_WAKE_CLICKS;
      csr_wdata <= {12'd0, wake};
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settle_gap_ms = deb;
      click_window_ms = win;
      wake_clicks = wake;
   endtask

   task automatic set_idling(input int phase);
      case (phase % 4)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 46;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 46;
         end
         default: begin
            send_idle_pct = 33;
            recv_stall_pct = 33;
         end
      endcase
   endtask

   // Random traffic with advancing timestamps; noise words on random channels, times and modes are not counted.
   task automatic random_events(input int count);
      int         handled;
      int         roll;
      logic [3:0] ch;
      handled = 0;
      while (handled < count) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            send_event(4'($urandom), $urandom, 2'($urandom));
         end else begin
            if ($urandom_range(99) < 10)
               traffic_mode = ($urandom_range(99) < 40) ? beq_pkg::MODE_POWER_DOWN
                                                         : 2'($urandom_range(3));
            roll = $urandom_range(99);
            if (roll < 70)
               stamp_ms += $urandom_range(600);
            else if (roll < 92)
               stamp_ms += $urandom_range(70000);
            else
               stamp_ms += $urandom;
            // Power-down traffic mostly hammers the external button to build click runs.
            roll = $urandom_range(99);
            if ((traffic_mode == beq_pkg::MODE_POWER_DOWN) ? (roll < 80) : (roll < 30)) begin
               ch = beq_pkg::CH_EXTERNAL;
            end else begin
               case ($urandom_range(3))
                  0: ch = beq_pkg::CH_BUTTON1;
                  1: ch = beq_pkg::CH_BUTTON2;
                  2: ch = beq_pkg::CH_BUTTON3;
                  default: ch = beq_pkg::CH_BUTTON4;
               endcase
            end
            send_event(ch, stamp_ms, traffic_mode);
            handled++;
         end
      end
   endtask

   // Plain buttons with the reset debounce interval, including the exact boundary.
   task automatic test_plain_buttons();
      send_event(beq_pkg::CH_BUTTON1, 32'd100, beq_pkg::MODE_NORMAL);
      send_event(beq_pkg::CH_BUTTON1, 32'd120, beq_pkg::MODE_NORMAL);
      send_event(beq_pkg::CH_BUTTON2, 32'd130, beq_pkg::MODE_POWER_UP);
      send_event(beq_pkg::CH_BUTTON3, 32'd150, beq_pkg::MODE_POWER_DOWN);
      send_event(beq_pkg::CH_BUTTON4, 32'd151, MODE_SPARE);
      send_event(beq_pkg::CH_BUTTON2, 32'd160, beq_pkg::MODE_NORMAL);
   endtask

   // Unused channels give an all-zero word whatever the timestamp or mode.
   task automatic test_unhandled_channels();
      send_event(4'd0, 32'hFFFF_FFFF, MODE_SPARE);
      send_event(4'd15, 32'h0000_0000, beq_pkg::MODE_NORMAL);
      send_event(4'd8, 32'hFFFF_FFFF, beq_pkg::MODE_POWER_DOWN);
      send_event(4'd3, 32'hAAAA_5555, beq_pkg::MODE_POWER_UP);
   endtask

   // External button in normal mode: hold timer, presses and releases skipped in power-up, repeated press.
   task automatic test_external_normal();
      send_event(beq_pkg::CH_EXTERNAL, 32'd1000, beq_pkg::MODE_NORMAL);
      send_event(beq_pkg::CH_EXTERNAL, 32'd1010, beq_pkg::MODE_POWER_UP);
      send_event(beq_pkg::CH_EXTERNAL, 32'd1020, beq_pkg::MODE_NORMAL);
      send_event(beq_pkg::CH_EXTERNAL, 32'd1100, MODE_SPARE);
      send_event(beq_pkg::CH_EXTERNAL, 32'd1200, beq_pkg::MODE_POWER_UP);
      send_event(beq_pkg::CH_EXTERNAL, 32'd1230, beq_pkg::MODE_NORMAL);
   endtask

   // Wake from power-down by quick clicks, then a click after the window expired.
   task automatic test_wake_clicks();
      send_event(beq_pkg::CH_EXTERNAL, 32'd2000, beq_pkg::MODE_POWER_DOWN);
      send_event(beq_pkg::CH_EXTERNAL, 32'd2010, beq_pkg::MODE_POWER_DOWN);
      send_event(beq_pkg::CH_EXTERNAL, 32'd2100, beq_pkg::MODE_POWER_DOWN);
      send_event(beq_pkg::CH_EXTERNAL, 32'd2110, beq_pkg::MODE_POWER_DOWN);
      send_event(beq_pkg::CH_EXTERNAL, 32'd2200, beq_pkg::MODE_POWER_DOWN);
      send_event(beq_pkg::CH_EXTERNAL, 32'd2210, beq_pkg::MODE_POWER_DOWN);
      send_event(beq_pkg::CH_EXTERNAL, 32'd2900, beq_pkg::MODE_POWER_DOWN);
      send_event(beq_pkg::CH_EXTERNAL, 32'd2910, beq_pkg::MODE_POWER_DOWN);
   endtask

   // Random phases over register extremes and every idling pattern.
   task automatic test_random_traffic();
      for (int p = 0; p < 8; p++) begin
         drain_results();
         case (p)
            0: apply_settings(16'd0, 16'd0, 4'd1);
            1: apply_settings(16'hFFFF, 16'hFFFF, 4'd15);
            2: apply_settings(16'd0, 16'hFFFF, 4'd0);
            3: apply_settings(16'hFFFF, 16'd0, 4'd1);
            4: apply_settings(16'd10, 16'd200, 4'd2);
            5: apply_settings(beq_pkg::DEBOUNCE_RESET, beq_pkg::CLICK_WIN_RESET,
                              beq_pkg::WAKE_CLICKS_RESET);
            default: apply_settings(16'($urandom_range(1000)), 16'($urandom_range(2000)),
                                    4'($urandom));
         endcase
         set_idling(p);
         // Some phases start near the top of the timestamp range so it wraps.
         stamp_ms = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(2000)
                                             : $urandom;
         traffic_mode = beq_pkg::MODE_NORMAL;
         random_events(42);
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure();
      drain_results();
      set_idling(0);
      hold_off_req = 1'b1;
      random_events(40);
      drain_results();
   endtask

   initial begin
      settle_gap_ms = beq_pkg::DEBOUNCE_RESET;
      click_window_ms = beq_pkg::CLICK_WIN_RESET;
      wake_clicks = beq_pkg::WAKE_CLICKS_RESET;
      sense_low = '1;
      last_accept_ms = '0;
      last_click_ms = '0;
      click_count = '0;
      external_held = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_plain_buttons();
      test_unhandled_channels();
      test_external_normal();
      test_wake_clicks();
      test_random_traffic();
      test_backpressure();
      drain_results();
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
rtl/beq_pkg.sv
rtl/beq_decide.sv
rtl/button_event_qualifier.sv
test/tb_button_event_qualifier.sv
